// File: rtl/vdac_pkg.sv
// types, constants and the divider table for the video display area control block
// no dependencies
package vdac_pkg;

  typedef enum logic [2:0] {
    KIND_RESET  = 3'd0,
    KIND_START  = 3'd1,
    KIND_HRANGE = 3'd2,
    KIND_VRANGE = 3'd3,
    KIND_MODE   = 3'd4,
    KIND_NONE   = 3'd5
  } req_kind_t;

  typedef struct packed {
    req_kind_t   kind;
    logic [23:0] cmd;
  } q_entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  localparam logic [11:0] CYCLES_PAL  = 12'd3406;
  localparam logic [11:0] CYCLES_NTSC = 12'd3413;
  localparam logic [8:0]  LINES_PAL   = 9'd314;
  localparam logic [8:0]  LINES_NTSC  = 9'd263;

  localparam logic [11:0] HBEGIN_RST  = 12'h200;
  localparam logic [11:0] HFINISH_RST = 12'hC00;
  localparam logic [9:0]  VBEGIN_RST  = 10'h010;
  localparam logic [9:0]  VFINISH_RST = 10'h250;

  localparam int DIV_STEPS = 6;   // two quotient bits per cycle over 12 bits

  function automatic logic [3:0] dot_divider(input logic [2:0] idx);
    logic [3:0] d;
    begin
      case (idx)
        3'd0:    d = 4'd10;
        3'd2:    d = 4'd8;
        3'd4:    d = 4'd5;
        3'd6:    d = 4'd4;
        default: d = 4'd7;
      endcase
      return d;
    end
  endfunction

endpackage

// File: rtl/vdac_front.sv
// front end: takes requests from the input stream and classifies them
// depends on vdac_pkg
module vdac_front import vdac_pkg::*; (
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // command_word
  input  logic [2:0]  s_axis_tuser,   // req_type
  input  q_status_t   q_stat,
  output logic        push,
  output q_entry_t    push_entry
);

  req_kind_t kind;

  always_comb begin
    unique case (s_axis_tuser)
      3'd0:    kind = KIND_RESET;
      3'd1:    kind = KIND_START;
      3'd2:    kind = KIND_HRANGE;
      3'd3:    kind = KIND_VRANGE;
      3'd4:    kind = KIND_MODE;
      default: kind = KIND_NONE;
    endcase
  end

  assign s_axis_tready    = !q_stat.full;
  assign push             = s_axis_tvalid && !q_stat.full;
  assign push_entry.kind  = kind;
  assign push_entry.cmd   = s_axis_tdata;

endmodule

// File: rtl/vdac_queue.sv
// short request queue between front and back end
// depends on vdac_pkg
module vdac_queue import vdac_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  q_entry_t  push_entry,
  input  logic      pop,
  output q_entry_t  head_entry,
  output q_status_t q_stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  q_entry_t          mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign head_entry   = mem[rd_ptr];
  assign q_stat.empty = (count == '0);
  assign q_stat.full  = (count == CNT_W'(DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/vdac_back.sv
// back end: applies requests to the display state, runs the width divider
// and holds the result register; depends on vdac_pkg
module vdac_back import vdac_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  q_entry_t    head_entry,
  input  q_status_t   q_stat,
  output logic        pop,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SETUP = 4'b0010,
    ST_DIV   = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t      state;
  logic        filter_crop;
  logic [9:0]  start_col;
  logic [8:0]  start_row;
  logic [11:0] hr_begin;
  logic [11:0] hr_finish;
  logic [9:0]  vr_begin;
  logic [9:0]  vr_finish;
  logic [7:0]  mode;

  logic [3:0]  divisor;
  logic [11:0] qb_sh;
  logic [11:0] qf_sh;
  logic [3:0]  rb;
  logic [3:0]  rf;
  logic [2:0]  step_cnt;
  logic        out_valid;
  logic [84:0] out_data;

  // one restoring division step: {remainder, shifter}
  function automatic logic [15:0] div_step(input logic [3:0] rem, input logic [11:0] sh,
                                           input logic [3:0] d);
    logic [4:0] trial;
    logic [3:0] rem_new;
    logic       qbit;
    begin
      trial = {rem, sh[11]};
      if (trial >= {1'b0, d}) begin
        rem_new = 4'(trial - {1'b0, d});
        qbit    = 1'b1;
      end else begin
        rem_new = trial[3:0];
        qbit    = 1'b0;
      end
      return {rem_new, sh[10:0], qbit};
    end
  endfunction

  logic [15:0] b1, b2, f1, f2;
  logic [11:0] cycles;
  logic [8:0]  lines;
  logic [11:0] hcount;
  logic [11:0] width_full;
  logic [9:0]  width;
  logic [8:0]  vb;
  logic [8:0]  vf;
  logic [9:0]  height10;
  logic [10:0] height;
  logic [9:0]  vsx;
  logic [9:0]  vsy;
  logic [10:0] vw;
  logic [10:0] vh;
  logic        load_out;

  always_comb begin
    b1 = div_step(rb, qb_sh, divisor);
    b2 = div_step(b1[15:12], b1[11:0], divisor);
    f1 = div_step(rf, qf_sh, divisor);
    f2 = div_step(f1[15:12], f1[11:0], divisor);

    cycles = mode[3] ? CYCLES_PAL : CYCLES_NTSC;
    lines  = mode[3] ? LINES_PAL : LINES_NTSC;

    hcount     = (qf_sh > qb_sh) ? qf_sh - qb_sh : '0;
    width_full = (hcount + 12'd2) & ~12'd3;
    width      = width_full[9:0];

    vb       = (vr_begin < {1'b0, lines}) ? vr_begin[8:0] : lines;
    vf       = (vr_finish < {1'b0, lines}) ? vr_finish[8:0] : lines;
    height10 = {1'b0, vf} - {1'b0, vb};
    height   = mode[5] ? {height10, 1'b0} : {height10[9], height10};

    vsx = start_col + {9'd0, filter_crop};
    vsy = {1'b0, start_row} + {9'd0, filter_crop};
    vw  = {1'b0, width} - {9'd0, filter_crop, 1'b0};
    vh  = height - {9'd0, filter_crop, 1'b0};
  end

  assign pop      = (state == ST_IDLE) && !q_stat.empty;
  assign load_out = (state == ST_DONE) && (!out_valid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_crop <= 1'b0;
    end else if (cfg_we) begin
      filter_crop <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      start_col <= '0;
      start_row <= '0;
      hr_begin  <= HBEGIN_RST;
      hr_finish <= HFINISH_RST;
      vr_begin  <= VBEGIN_RST;
      vr_finish <= VFINISH_RST;
      mode      <= '0;
      step_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (!q_stat.empty) begin
            case (head_entry.kind)
              KIND_RESET: begin
                start_col <= '0;
                start_row <= '0;
                hr_begin  <= HBEGIN_RST;
                hr_finish <= HFINISH_RST;
                vr_begin  <= VBEGIN_RST;
                vr_finish <= VFINISH_RST;
                mode      <= '0;
              end
              KIND_START: begin
                start_col <= {head_entry.cmd[9:1], 1'b0};
                start_row <= head_entry.cmd[18:10];
              end
              KIND_HRANGE: begin
                hr_begin  <= head_entry.cmd[11:0];
                hr_finish <= head_entry.cmd[23:12];
              end
              KIND_VRANGE: begin
                vr_begin  <= head_entry.cmd[9:0];
                vr_finish <= head_entry.cmd[19:10];
              end
              KIND_MODE: begin
                mode <= head_entry.cmd[7:0];
              end
              default: ;
            endcase
            state <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          step_cnt <= '0;
          state    <= ST_DIV;
        end
        ST_DIV: begin
          step_cnt <= step_cnt + 1'b1;
          if (step_cnt == 3'(DIV_STEPS - 1)) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (load_out) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // divider datapath
  always_ff @(posedge clk) begin
    if (state == ST_SETUP) begin
      divisor <= dot_divider({mode[1:0], mode[6]});
      qb_sh   <= (hr_begin < cycles) ? hr_begin : cycles;
      qf_sh   <= (hr_finish < cycles) ? hr_finish : cycles;
      rb      <= '0;
      rf      <= '0;
    end else if (state == ST_DIV) begin
      rb    <= b2[15:12];
      qb_sh <= b2[11:0];
      rf    <= f2[15:12];
      qf_sh <= f2[11:0];
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data <= {mode[5], mode[4], mode[3], vh, vw, vsy, vsx, height, width,
                   start_row, start_col};
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'b000, out_data};

endmodule

// File: rtl/video_display_area_control_unit.sv
// video display area control: top level joining front end, queue and back end
// depends on vdac_pkg, vdac_front, vdac_queue, vdac_back
//
// input stream: tuser carries the request kind (reset, display start, horizontal
// range, vertical range, display mode), tdata the 24-bit command word
// output stream: one result per request with start, display size, viewport and
// the mode flags
// cfg_we / cfg_wdata write the crop enable used for the viewport
// a request enters the queue at accept; the back end takes it from the queue when idle,
// applies it, clamps the ranges and runs a two-bit-per-cycle divider; the result
// is then loaded into the result register
// the back end takes the next request only after the result load: take, setup, the
// divider steps and the result load
// the queue holds QUEUE_DEPTH requests, so the input keeps taking requests while
// a result waits; when the receiver stalls the result register holds and the
// back end waits, and tready drops once the queue is full
// reset restores the display state defaults, clears crop enable and empties
// the queue
module video_display_area_control_unit import vdac_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // command_word
  input  logic [2:0]  s_axis_tuser,   // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // start_x, start_y, disp_width, disp_height, view_start_x, view_start_y,
  // view_width, view_height, pal_mode, color_24bit, interlaced, zero pad
  output logic [87:0] m_axis_tdata
);

  q_status_t q_stat;
  q_entry_t  push_entry;
  q_entry_t  head_entry;
  logic      push;
  logic      pop;

  vdac_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_stat        (q_stat),
    .push          (push),
    .push_entry    (push_entry)
  );

  vdac_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head_entry (head_entry),
    .q_stat     (q_stat)
  );

  vdac_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .head_entry    (head_entry),
    .q_stat        (q_stat),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    q_stat.full |-> !push)
    else $error("request pushed into full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty)
    else $error("request popped from empty queue");

  a_push_leaves_nonempty: assert property (@(posedge clk) disable iff (rst)
    push |=> !q_stat.empty)
    else $error("queue empty after a request was pushed");

endmodule

// File: sim/video_display_area_control_unit_tb.sv
// testbench for video_display_area_control_unit: a table of directed requests, then random
// phases across both crop settings, each result checked field by field against its table entry or a local predictor
// depends on vdac_pkg and video_display_area_control_unit
`timescale 1ns / 100ps

module video_display_area_control_unit_tb import vdac_pkg::*;;

  localparam logic [2:0] KIND_LAST = 3'd7;
  localparam int SCAN_CYC_PAL = 3406;
  localparam int SCAN_CYC_NTSC = 3413;
  localparam int FIELD_LINES_PAL = 263 + 51;
  localparam int FIELD_LINES_NTSC = 263;
  localparam int DOT_DIV [8] = '{10, 7, 8, 7, 5, 7, 4, 7};
  localparam int IDLE_MARGIN = 20;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 3000;
  localparam int RAND_PHASES = 10;
  localparam int ITEMS_PER_PHASE = 110;

  // result word layout, lowest field last
  typedef struct packed {
    logic [2:0]         pad;
    logic               interlaced;
    logic               color_24bit;
    logic               pal_mode;
    logic signed [10:0] view_height;
    logic signed [10:0] view_width;
    logic [9:0]         view_start_y;
    logic [9:0]         view_start_x;
    logic signed [10:0] disp_height;
    logic [9:0]         disp_width;
    logic [8:0]         start_y;
    logic [9:0]         start_x;
  } area_word_t;

  typedef struct packed {
    logic [9:0]  col;
    logic [8:0]  row;
    logic [11:0] h_begin;
    logic [11:0] h_finish;
    logic [9:0]  v_begin;
    logic [9:0]  v_finish;
    logic [7:0]  mode;
  } disp_state_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [23:0] cmd;
    logic        crop;
    logic        typed;
    area_word_t  want;
  } req_row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_wdata = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // command_word
  logic [2:0]  s_axis_tuser = '0;   // req_type
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // start_x, start_y, disp_width, disp_height, view_start_x, view_start_y,
  // view_width, view_height, pal_mode, color_24bit, interlaced, zero pad
  logic [87:0] m_axis_tdata;

  area_word_t  area_expect_q [$];
  req_row_t    directed_rows [$];
  disp_state_t disp_model;
  bit          crop_model = 1'b0;
  bit          hold_off_req = 1'b0;
  int          mismatch_count = 0;
  int          stall_cycles = 0;
  area_word_t  got_area;
  area_word_t  want_area;

  video_display_area_control_unit DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic disp_state_t disp_defaults();
    disp_state_t s;
    s.col = '0;
    s.row = '0;
    s.h_begin = 12'h200;
    s.h_finish = 12'hC00;
    s.v_begin = 10'h010;
    s.v_finish = 10'h250;
    s.mode = '0;
    return s;
  endfunction

  function automatic area_word_t area_word(int sx, int sy, int w, int h, int vsx, int vsy,
                                           int vw, int vh, bit pal, bit rgb, bit ilace);
    area_word_t a;
    a.pad = '0;
    a.start_x = 10'(sx);
    a.start_y = 9'(sy);
    a.disp_width = 10'(w);
    a.disp_height = 11'(h);
    a.view_start_x = 10'(vsx);
    a.view_start_y = 10'(vsy);
    a.view_width = 11'(vw);
    a.view_height = 11'(vh);
    a.pal_mode = pal;
    a.color_24bit = rgb;
    a.interlaced = ilace;
    return a;
  endfunction

  function automatic disp_state_t apply_request(disp_state_t s, logic [2:0] kind,
                                                logic [23:0] cmd);
    case (kind)
      KIND_RESET: s = disp_defaults();
      KIND_START: begin
        s.col = {cmd[9:1], 1'b0};
        s.row = cmd[18:10];
      end
      KIND_HRANGE: begin
        s.h_begin = cmd[11:0];
        s.h_finish = cmd[23:12];
      end
      KIND_VRANGE: begin
        s.v_begin = cmd[9:0];
        s.v_finish = cmd[19:10];
      end
      KIND_MODE: s.mode = cmd[7:0];
      default: ;
    endcase
    return s;
  endfunction

  function automatic area_word_t area_of(disp_state_t s, bit crop);
    int div, cyc, lines, hb, hf, hcyc, width, vb, vf, height, c;
    div = DOT_DIV[{s.mode[1:0], s.mode[6]}];
    cyc = s.mode[3] ? SCAN_CYC_PAL : SCAN_CYC_NTSC;
    lines = s.mode[3] ? FIELD_LINES_PAL : FIELD_LINES_NTSC;
    hb = (int'(s.h_begin) < cyc) ? int'(s.h_begin) : cyc;
    hf = (int'(s.h_finish) < cyc) ? int'(s.h_finish) : cyc;
    hb = (hb / div) * div;
    hf = (hf / div) * div;
    hcyc = (hf > hb) ? hf - hb : 0;
    width = ((hcyc / div) + 2) & ~3;
    vb = (int'(s.v_begin) < lines) ? int'(s.v_begin) : lines;
    vf = (int'(s.v_finish) < lines) ? int'(s.v_finish) : lines;
    height = vf - vb;
    if (height > lines) height = lines;
    if (s.mode[5]) height = height * 2;
    c = crop ? 1 : 0;
    return area_word(s.col, s.row, width, height, s.col + c, s.row + c, width - 2 * c,
                     height - 2 * c, s.mode[3], s.mode[4], s.mode[5]);
  endfunction

  function automatic logic [11:0] pick_bound(int full, int near_lo, int near_hi);
    case ($urandom_range(0, 4))
      0: return 12'd0;
      1: return 12'(full);
      2: return 12'($urandom_range(near_lo, near_hi));
      3: return 12'($urandom_range(0, full));
      default: return 12'($urandom_range(16, near_lo));
    endcase
  endfunction

  function automatic logic [2:0] random_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return KIND_RESET;
    if (r < 12) return 3'($urandom_range(int'(KIND_NONE), int'(KIND_LAST)));
    return 3'($urandom_range(int'(KIND_START), int'(KIND_MODE)));
  endfunction

  function automatic logic [23:0] random_cmd(logic [2:0] kind);
    logic [23:0] cmd;
    cmd = 24'($urandom);
    case (kind)
      KIND_START: if ($urandom_range(0, 7) == 0) cmd = '1;
      KIND_HRANGE: cmd = {pick_bound(12'hFFF, 3400, 3420), pick_bound(12'hFFF, 3400, 3420)};
      KIND_VRANGE: cmd[19:0] = {10'(pick_bound(10'h3FF, 255, 320)),
                                10'(pick_bound(10'h3FF, 255, 320))};
      default: ;
    endcase
    return cmd;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns: %s mismatch, got %0d expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic check_field(input string what, input int got, input int want);
    if (got != want) report_mismatch(what, got, want);
  endtask

  task automatic add_row(input logic [2:0] kind, input logic [23:0] cmd, input bit crop,
                         input bit typed, input area_word_t want);
    req_row_t r;
    r.kind = kind;
    r.cmd = cmd;
    r.crop = crop;
    r.typed = typed;
    r.want = want;
    directed_rows.push_back(r);
  endtask

  task automatic send_request(input logic [2:0] kind, input logic [23:0] cmd, input bit typed,
                              input area_word_t want);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= cmd;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    disp_model = apply_request(disp_model, kind, cmd);
    area_expect_q.push_back(typed ? want : area_of(disp_model, crop_model));
  endtask

  task automatic sender_gap(input int cycles);
    s_axis_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (area_expect_q.size() != 0) @(posedge clk);
    repeat (IDLE_MARGIN) @(posedge clk);
  endtask

  task automatic set_crop(input bit value);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    crop_model = value;
  endtask

  // receiver: stretches of always ready, random stalls and a fixed pattern, plus one long hold
  initial begin
    int mode, span, k;
    while (rst) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        mode = $urandom_range(0, 2);
        span = $urandom_range(20, 120);
        for (k = 0; k < span; k++) begin
          case (mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 9) > 3);
            default: m_axis_tready <= (k % 5 == 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (area_expect_q.size() == 0) begin
        report_mismatch("result with no request pending", 0, 0);
      end else begin
        want_area = area_expect_q.pop_front();
        got_area = m_axis_tdata;
        check_field("start_x", got_area.start_x, want_area.start_x);
        check_field("start_y", got_area.start_y, want_area.start_y);
        check_field("disp_width", got_area.disp_width, want_area.disp_width);
        check_field("disp_height", got_area.disp_height, want_area.disp_height);
        check_field("view_start_x", got_area.view_start_x, want_area.view_start_x);
        check_field("view_start_y", got_area.view_start_y, want_area.view_start_y);
        check_field("view_width", got_area.view_width, want_area.view_width);
        check_field("view_height", got_area.view_height, want_area.view_height);
        check_field("pal_mode", got_area.pal_mode, want_area.pal_mode);
        check_field("color_24bit", got_area.color_24bit, want_area.color_24bit);
        check_field("interlaced", got_area.interlaced, want_area.interlaced);
        check_field("pad", got_area.pad, want_area.pad);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (!s_axis_tvalid && area_expect_q.size() == 0)) begin
      stall_cycles <= 0;
    end else if (stall_cycles < STALL_LIMIT) begin
      stall_cycles <= stall_cycles + 1;
    end else begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int p, counted, burst_left;
    bit gappy;
    logic [2:0] kind;
    logic [23:0] cmd;
    disp_model = disp_defaults();

    // defaults, reversed ranges, all mode bits and the widest start
    add_row(KIND_RESET, 24'h000000, 1'b0, 1'b1,
            area_word(0, 0, 256, 247, 0, 0, 256, 247, 0, 0, 0));
    add_row(KIND_HRANGE, 24'h000FFF, 1'b0, 1'b1,
            area_word(0, 0, 0, 247, 0, 0, 0, 247, 0, 0, 0));
    add_row(KIND_MODE, 24'h0000FF, 1'b0, 1'b1,
            area_word(0, 0, 0, 596, 0, 0, 0, 596, 1, 1, 1));
    add_row(KIND_VRANGE, 24'h0003FF, 1'b0, 1'b1,
            area_word(0, 0, 0, -628, 0, 0, 0, -628, 1, 1, 1));
    add_row(KIND_START, 24'h07FFFF, 1'b0, 1'b1,
            area_word(1022, 511, 0, -628, 1022, 511, 0, -628, 1, 1, 1));
    add_row(KIND_LAST, 24'hFFFFFF, 1'b0, 1'b1,
            area_word(1022, 511, 0, -628, 1022, 511, 0, -628, 1, 1, 1));
    add_row(KIND_HRANGE, 24'hFFF000, 1'b0, 1'b1,
            area_word(1022, 511, 488, -628, 1022, 511, 488, -628, 1, 1, 1));
    // every dot-clock divider
    add_row(KIND_MODE, 24'h000000, 1'b0, 1'b0, '0);
    add_row(KIND_MODE, 24'h000040, 1'b0, 1'b0, '0);
    add_row(KIND_MODE, 24'h000001, 1'b0, 1'b0, '0);
    add_row(KIND_MODE, 24'h000041, 1'b0, 1'b0, '0);
    add_row(KIND_MODE, 24'h000002, 1'b0, 1'b0, '0);
    add_row(KIND_MODE, 24'h000042, 1'b0, 1'b0, '0);
    add_row(KIND_MODE, 24'h000003, 1'b0, 1'b0, '0);
    add_row(KIND_MODE, 24'h000043, 1'b0, 1'b0, '0);
    add_row(KIND_VRANGE, 24'h0FFC00, 1'b0, 1'b0, '0);
    add_row(KIND_MODE, 24'h000038, 1'b0, 1'b0, '0);
    // crop on: reset keeps it, viewport extremes
    add_row(KIND_RESET, 24'hFFFFFF, 1'b1, 1'b1,
            area_word(0, 0, 256, 247, 1, 1, 254, 245, 0, 0, 0));
    add_row(KIND_START, 24'h07FFFF, 1'b1, 1'b0, '0);
    add_row(KIND_MODE, 24'h000028, 1'b1, 1'b0, '0);
    add_row(KIND_VRANGE, 24'h0003FF, 1'b1, 1'b0, '0);
    add_row(KIND_HRANGE, 24'h000FFF, 1'b1, 1'b0, '0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].crop != crop_model) set_crop(directed_rows[i].crop);
      send_request(directed_rows[i].kind, directed_rows[i].cmd, directed_rows[i].typed,
                   directed_rows[i].want);
    end

    for (p = 0; p < RAND_PHASES; p++) begin
      set_crop(p[0]);
      // phase 3 runs flat out into the long hold, every third phase has no gaps
      gappy = (p % 3 != 2) && (p != 3);
      if (p == 3) hold_off_req = 1'b1;
      burst_left = 0;
      counted = 0;
      while (counted < ITEMS_PER_PHASE) begin
        if (p == 5 && counted == ITEMS_PER_PHASE / 2) wait_idle();
        if (burst_left == 0) begin
          if (gappy) sender_gap($urandom_range(1, 15));
          burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        kind = random_kind();
        cmd = random_cmd(kind);
        send_request(kind, cmd, 1'b0, '0);
        counted++;
      end
    end

    wait_idle();
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/vdac_pkg.sv
rtl/vdac_front.sv
rtl/vdac_queue.sv
rtl/vdac_back.sv
rtl/video_display_area_control_unit.sv
sim/video_display_area_control_unit_tb.sv
